@@ hw/rtl/pncc_pkg.sv @@
// Package for the PN code phase correlator: widths, register indexes,
// reset values and the types shared between the cell row and the top level.
// No dependencies.
package pncc_pkg;

    // Fixed field widths
    localparam int SUM_W       = 33;
    localparam int WINDOW_W    = 16;
    localparam int CODE_BITS   = 15;
    localparam int IDX_W       = 4;
    localparam int POS_W       = 7;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // Defaults for the top level parameters
    localparam int DEFAULT_CODE_LENGTH  = 15;
    localparam int DEFAULT_SAMPLE_WIDTH = 16;

    // Register reset values
    localparam logic [WINDOW_W-1:0]  WINDOW_RESET = 16'd2310;
    localparam logic [CODE_BITS-1:0] CODE_RESET   = 15'd11407;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CODE_WORD     = 4'd1;

    // Control handed to every cell
    typedef struct packed {
        logic step;   // a sample word is accepted this cycle
        logic clear;  // this sample closes the window
        logic load;   // chip reload after a code write
    } pncc_ctrl_t;

    // One result word
    typedef struct packed {
        logic             window_done;
        logic             delay_found;
        logic [IDX_W-1:0] delay_index;
    } pncc_result_t;

endpackage

@@ hw/rtl/pncc_sample_if.sv @@
// Sample channel: valid/ready handshake carrying one signed sample word.
// Depends on nothing.
interface pncc_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ hw/rtl/pncc_result_if.sv @@
// Result channel: valid/ready handshake carrying the window decision word.
// Depends on nothing.
interface pncc_result_if;
    logic       valid;
    logic       ready;
    logic       window_done;
    logic       delay_found;
    logic [3:0] delay_index;

    modport source (output valid, output window_done, output delay_found,
                    output delay_index, input ready);
    modport sink   (input valid, input window_done, input delay_found,
                    input delay_index, output ready);
endinterface

@@ hw/rtl/pncc_cfg_if.sv @@
// Configuration write channel: valid/ready with register index and data.
// Depends on nothing.
interface pncc_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/pn_code_phase_correlator.sv @@
// PN code phase correlator: a row of CODE_LENGTH cells, one per cyclic code
// shift, each adding or subtracting every sample into a 33-bit saturating sum.
// Depends on pncc_pkg, the three channel interfaces, pncc_cell, pncc_out_buf.
//
// One sample word is taken per clock unless stalled. All cells update in the
// cycle a sample is accepted, and its result word (window_done, delay_found,
// delay_index) is in the output buffer on the next cycle. The two-word output
// buffer sets the stall point: samples stop only while both buffer words are
// held by a stalled result channel. Each sample gives exactly one result word;
// delay_index names the lowest shift whose sum is negative when window_length
// samples have been seen, after which all sums and the count restart from
// zero. The chip pointer moves on every sample; a code_word write reloads
// the chips at the current pointer. Configuration writes are always ready;
// the user, not the block, must make them while no sample is in flight.
module pn_code_phase_correlator #(
    parameter int CODE_LENGTH  = pncc_pkg::DEFAULT_CODE_LENGTH,
    parameter int SAMPLE_WIDTH = pncc_pkg::DEFAULT_SAMPLE_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    pncc_sample_if.sink   samples,
    pncc_result_if.source results,
    pncc_cfg_if.sink      cfg
);
    import pncc_pkg::*;

    localparam int CI_W = $clog2(CODE_LENGTH);

    logic [WINDOW_W-1:0] window_length_reg;
    logic [WINDOW_W-1:0] window_length_next;
    logic [WINDOW_W-1:0] count_reg;
    logic [WINDOW_W-1:0] count_next;
    logic [WINDOW_W-1:0] count_inc;
    logic [CI_W-1:0]     ci_reg;
    logic [CI_W-1:0]     ci_next;
    logic                cfg_we;
    logic                code_load;
    logic                win_end;
    logic                buf_full;
    pncc_ctrl_t          ctrl;
    pncc_result_t        result;

    logic [CODE_LENGTH-1:0] chip;
    logic [CODE_LENGTH-1:0] load_chip;
    logic [CODE_LENGTH-1:0] first_neg;
    logic [CODE_LENGTH:0]   hit;

    // Configuration decode
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid & cfg.ready;

    always_comb
    begin
        window_length_next = window_length_reg;
        code_load          = 1'b0;
        unique case (cfg.index)
            REG_WINDOW_LENGTH: window_length_next = cfg_we ? cfg.data : window_length_reg;
            REG_CODE_WORD:     code_load          = cfg_we;
            default:           ;
        endcase
    end

    // Sample handshake and window count
    assign samples.ready = ~buf_full;
    assign count_inc     = count_reg + 1'b1;
    assign win_end       = (count_inc == window_length_reg);

    assign ctrl.step  = samples.valid & samples.ready;
    assign ctrl.clear = win_end;
    assign ctrl.load  = code_load;

    always_comb
    begin
        count_next = count_reg;
        ci_next    = ci_reg;
        if (ctrl.step)
        begin
            count_next = win_end ? '0 : count_inc;
            ci_next    = (ci_reg == CI_W'(CODE_LENGTH - 1)) ? '0 : ci_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RESET;
            count_reg         <= '0;
            ci_reg            <= '0;
        end
        else
        begin
            window_length_reg <= window_length_next;
            count_reg         <= count_next;
            ci_reg            <= ci_next;
        end
    end

    // Cell row; chips rotate towards shift 0
    assign hit[0] = 1'b0;

    for (genvar k = 0; k < CODE_LENGTH; k++)
    begin : g_cell
        localparam logic INIT = (k < CODE_BITS) ? CODE_RESET[k % CODE_BITS] : 1'b0;

        logic [POS_W-1:0] pos_sum;
        logic [POS_W-1:0] pos;

        // Chip for this shift at the current pointer, from the written code
        always_comb
        begin
            pos_sum = POS_W'(ci_reg) + POS_W'(k);
            pos     = (pos_sum >= POS_W'(CODE_LENGTH)) ? pos_sum - POS_W'(CODE_LENGTH)
                                                       : pos_sum;
        end

        assign load_chip[k] = (pos < POS_W'(CODE_BITS)) ? cfg.data[pos[3:0]] : 1'b0;

        pncc_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .CHIP_INIT    (INIT)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .load_chip (load_chip[k]),
            .chip_in   (chip[(k + 1) % CODE_LENGTH]),
            .sample    (samples.sample),
            .hit_in    (hit[k]),
            .chip_out  (chip[k]),
            .hit_out   (hit[k + 1]),
            .first_neg (first_neg[k])
        );
    end

    // Result word: at most one first_neg bit is set
    always_comb
    begin
        result.window_done = win_end;
        result.delay_found = win_end & hit[CODE_LENGTH];
        result.delay_index = '0;
        for (int k = 0; k < CODE_LENGTH; k++)
        begin
            if (win_end && first_neg[k])
            begin
                result.delay_index = result.delay_index | IDX_W'(k);
            end
        end
    end

    pncc_out_buf u_out_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (ctrl.step),
        .din     (result),
        .full    (buf_full),
        .results (results)
    );

endmodule

@@ hw/rtl/pncc_cell.sv @@
// One correlator cell: holds the chip for its code shift and the saturating
// sum for that shift; passes its chip to the lower neighbour on each sample.
// Depends on pncc_pkg.
module pncc_cell #(
    parameter int   SAMPLE_WIDTH = 16,
    parameter logic CHIP_INIT    = 1'b0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pncc_pkg::pncc_ctrl_t           ctrl,
    input  logic                           load_chip,
    input  logic                           chip_in,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           hit_in,
    output logic                           chip_out,
    output logic                           hit_out,
    output logic                           first_neg
);
    import pncc_pkg::*;

    logic                    chip_reg;
    logic                    chip_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_new;
    logic signed [SUM_W:0]   sample_ext;
    logic signed [SUM_W:0]   wide;
    logic                    neg;

    // Add or subtract the sample, clamp at the sum limits
    always_comb
    begin
        sample_ext = {{(SUM_W + 1 - SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};
        wide = {sum_reg[SUM_W-1], sum_reg} + (chip_reg ? sample_ext : -sample_ext);
        if (wide[SUM_W] != wide[SUM_W-1])
        begin
            sum_new = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                  : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_new = wide[SUM_W-1:0];
        end
    end

    // Priority chain: lowest negative shift wins
    assign neg       = sum_new[SUM_W-1];
    assign first_neg = neg & ~hit_in;
    assign hit_out   = neg | hit_in;
    assign chip_out  = chip_reg;

    // Next state
    always_comb
    begin
        chip_next = chip_reg;
        sum_next  = sum_reg;
        if (ctrl.load)
        begin
            chip_next = load_chip;
        end
        else if (ctrl.step)
        begin
            chip_next = chip_in;
        end
        if (ctrl.step)
        begin
            sum_next = ctrl.clear ? '0 : sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_reg <= CHIP_INIT;
            sum_reg  <= '0;
        end
        else
        begin
            chip_reg <= chip_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

@@ hw/rtl/pncc_out_buf.sv @@
// Two-word output buffer between the correlator row and the result channel,
// so a stalled result does not stop the sample stream at once.
// Depends on pncc_pkg and pncc_result_if.
module pncc_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pncc_pkg::pncc_result_t din,
    output logic                   full,
    pncc_result_if.source          results
);
    import pncc_pkg::*;

    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    pncc_result_t slot0_reg;
    pncc_result_t slot1_reg;
    logic         pop;

    assign pop  = results.valid & results.ready;
    assign full = (count_reg == 2'd2);

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Word storage, head in slot 0
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            slot0_reg <= (count_reg == 2'd2) ? slot1_reg : din;
            slot1_reg <= din;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= din;
            end
            else
            begin
                slot1_reg <= din;
            end
        end
    end

    assign results.valid       = (count_reg != 2'd0);
    assign results.window_done = slot0_reg.window_done;
    assign results.delay_found = slot0_reg.delay_found;
    assign results.delay_index = slot0_reg.delay_index;

endmodule

@@ tb/sv/tb_pn_code_phase_correlator.sv @@
// Testbench for pn_code_phase_correlator: drives sample words and register
// writes, predicts each decision word in step with the block and compares them.
// Depends on pncc_pkg, the three channel interfaces and the block itself.
module tb_pn_code_phase_correlator;
    timeunit 1ns;
    timeprecision 1ps;

    import pncc_pkg::*;

    localparam int     CODE_LEN     = DEFAULT_CODE_LENGTH;
    localparam int     SAMPLE_W     = DEFAULT_SAMPLE_WIDTH;
    localparam longint SUM_HI       = 64'sd4294967295;
    localparam longint SUM_LO       = -64'sd4294967296;
    localparam int     DRAIN_CYCLES = 8;

    // Index with no register behind it; writes to it must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 4'hF;

    // Decisions that can be read straight off the arithmetic
    localparam pncc_result_t DEC_IDLE  = '{window_done: 1'b0, delay_found: 1'b0,
                                           delay_index: '0};
    localparam pncc_result_t DEC_CLEAR = '{window_done: 1'b1, delay_found: 1'b0,
                                           delay_index: '0};
    localparam pncc_result_t DEC_HIT0  = '{window_done: 1'b1, delay_found: 1'b1,
                                           delay_index: '0};

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

    // One row of the directed table: a register write or a sample word
    typedef struct {
        row_kind_e               kind;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0]   value;
        bit                      quoted;
        pncc_result_t            decision;
    } stim_row_t;

    // Decision typed into the table, held until its sample is taken
    typedef struct {
        bit           quoted;
        pncc_result_t decision;
    } quote_t;

    logic clk = 1'b0;
    logic rst_n;

    pncc_sample_if #(.SAMPLE_WIDTH(SAMPLE_W)) sample_ch ();
    pncc_result_if                            result_ch ();
    pncc_cfg_if                               cfg_ch ();

    pn_code_phase_correlator #(
        .CODE_LENGTH  (CODE_LEN),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    // Predictor state
    logic [WINDOW_W-1:0]     window_reg;
    logic [CODE_BITS-1:0]    code_reg;
    int                      chip_pos;
    logic [WINDOW_W-1:0]     sample_cnt;
    logic signed [SUM_W-1:0] shift_sum [CODE_LEN];

    pncc_result_t due_decisions [$];
    quote_t       quoted_decisions [$];
    int           mismatches = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run one sample through the correlator bank, return its decision word
    function automatic pncc_result_t correlate_sample(input logic signed [SAMPLE_W-1:0] smp);
        pncc_result_t res;
        longint       acc;
        int           pos;
        res = DEC_IDLE;
        for (int k = 0; k < CODE_LEN; k++)
        begin
            pos = (chip_pos + k) % CODE_LEN;
            // chips past the register width read as minus one
            if (pos < CODE_BITS && code_reg[pos])
                acc = longint'(shift_sum[k]) + longint'(smp);
            else
                acc = longint'(shift_sum[k]) - longint'(smp);
            if (acc > SUM_HI)
                acc = SUM_HI;
            else if (acc < SUM_LO)
                acc = SUM_LO;
            shift_sum[k] = acc[SUM_W-1:0];
        end
        chip_pos   = (chip_pos + 1) % CODE_LEN;
        sample_cnt = sample_cnt + 1'b1;
        if (sample_cnt == window_reg)
        begin
            res.window_done = 1'b1;
            for (int k = 0; k < CODE_LEN; k++)
            begin
                if (!res.delay_found && shift_sum[k] < 0)
                begin
                    res.delay_found = 1'b1;
                    res.delay_index = IDX_W'(k);
                end
            end
            foreach (shift_sum[k])
                shift_sum[k] = '0;
            sample_cnt = '0;
        end
        return res;
    endfunction

    // Samples still needed to close the current window (16-bit count wraps)
    function automatic int samples_to_window_end();
        logic [WINDOW_W-1:0] gap;
        gap = window_reg - sample_cnt;
        return (gap == '0) ? (1 << WINDOW_W) : int'(gap);
    endfunction

    function automatic void compare_field(input string field, input logic [IDX_W-1:0] want,
                                          input logic [IDX_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input bit positive);
        if (positive && $urandom_range(3) != 0)
            return SAMPLE_W'($urandom_range(32767, 1));
        case ($urandom_range(5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return SAMPLE_W'($urandom_range(20) - 10);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [CODE_BITS-1:0] pick_code();
        int pos;
        pos = $urandom_range(CODE_BITS - 1);
        case ($urandom_range(4))
            0:       return '1;
            1:       return '0;
            2:       return ~(CODE_BITS'(1) << pos);   // one minus chip
            3:       return CODE_BITS'(1) << pos;      // one plus chip
            default: return CODE_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [WINDOW_W-1:0] pick_window();
        case ($urandom_range(7))
            0:       return 16'd1;
            1:       return 16'd2;
            2:       return WINDOW_W'($urandom_range(400, 100));
            default: return WINDOW_W'($urandom_range(24, 1));
        endcase
    endfunction

    // Offer one sample word, idling first at the current rate
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit quoted,
                               input pncc_result_t decision);
        quote_t q;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        q.quoted   = quoted;
        q.decision = decision;
        quoted_decisions.push_back(q);
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // Stop sending and hold off until every decision word is back
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_decisions.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= reg_index;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result sink back-pressure
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watch all three channels: check results, track writes, predict samples
    always @(posedge clk)
    begin : watch
        pncc_result_t want;
        pncc_result_t decision;
        quote_t       q;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (due_decisions.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: decision word expected none got %b/%b/%0d", $time,
                             result_ch.window_done, result_ch.delay_found,
                             result_ch.delay_index);
                end
                else
                begin
                    want = due_decisions.pop_front();
                    compare_field("window_done", IDX_W'(want.window_done),
                                  IDX_W'(result_ch.window_done));
                    compare_field("delay_found", IDX_W'(want.delay_found),
                                  IDX_W'(result_ch.delay_found));
                    compare_field("delay_index", want.delay_index, result_ch.delay_index);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_WINDOW_LENGTH: window_reg = cfg_ch.data;
                    REG_CODE_WORD:     code_reg   = cfg_ch.data[CODE_BITS-1:0];
                    default:           ;
                endcase
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                decision = correlate_sample(sample_ch.sample);
                q        = quoted_decisions.pop_front();
                due_decisions.push_back(q.quoted ? q.decision : decision);
            end
        end
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t rows [$];
        bit        positive;

        rst_n            = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        window_reg       = WINDOW_RESET;
        code_reg         = CODE_RESET;
        chip_pos         = 0;
        sample_cnt       = '0;
        foreach (shift_sum[k])
            shift_sum[k] = '0;

        // Directed table
        // reset settings: mid-window, nothing reported
        rows.push_back('{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'h8000, 1'b1, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'h0000, 1'b1, DEC_IDLE});
        // close the open window so the count restarts at zero
        rows.push_back('{ROW_WRITE, REG_WINDOW_LENGTH, 16'd4, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'h1234, 1'b0, DEC_IDLE});
        // one-sample windows, all chips plus: sum sign is the sample sign
        rows.push_back('{ROW_WRITE, REG_WINDOW_LENGTH, 16'd1, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_WRITE, REG_CODE_WORD, 16'h7FFF, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'h0001, 1'b1, DEC_CLEAR});
        rows.push_back('{ROW_SAMPLE, '0, 16'hFFFF, 1'b1, DEC_HIT0});
        rows.push_back('{ROW_SAMPLE, '0, 16'h0000, 1'b1, DEC_CLEAR});
        // all chips minus: sign flips, extremes of the sample
        rows.push_back('{ROW_WRITE, REG_CODE_WORD, 16'h0000, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, DEC_HIT0});
        rows.push_back('{ROW_SAMPLE, '0, 16'h8000, 1'b1, DEC_CLEAR});
        // write to an unused index is dropped; window stays at one
        rows.push_back('{ROW_WRITE, REG_SPARE, 16'h0000, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'hFFFB, 1'b1, DEC_CLEAR});
        // single minus chip walks through the shifts
        rows.push_back('{ROW_WRITE, REG_CODE_WORD, 16'h3FFF, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'd100, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'd100, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'd100, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_WRITE, REG_WINDOW_LENGTH, 16'd3, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'd300, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'hFF38, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'd7, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_WRITE, REG_WINDOW_LENGTH, 16'd2, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_WRITE, REG_CODE_WORD, {1'b0, CODE_RESET}, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'h5555, 1'b0, DEC_IDLE});
        rows.push_back('{ROW_SAMPLE, '0, 16'hAAAA, 1'b0, DEC_IDLE});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(rows[i].reg_index, rows[i].value);
            end
            else
                send_sample(rows[i].value, rows[i].quoted, rows[i].decision);
        end

        // Window lowered below the running count: count runs on, no decision
        wait_idle();
        write_reg(REG_WINDOW_LENGTH, 16'd40);
        repeat (samples_to_window_end() + 30)
            send_sample(pick_sample(1'b0), 1'b0, DEC_IDLE);
        wait_idle();
        write_reg(REG_WINDOW_LENGTH, 16'd10);
        repeat (20)
            send_sample(pick_sample(1'b0), 1'b0, DEC_IDLE);
        // raised above the count again: closes at the new length
        wait_idle();
        write_reg(REG_WINDOW_LENGTH, 16'd64);
        repeat (samples_to_window_end())
            send_sample(pick_sample(1'b0), 1'b0, DEC_IDLE);
        // zero window: no decision during a short run, then closed normally
        wait_idle();
        write_reg(REG_WINDOW_LENGTH, 16'd0);
        repeat (40)
            send_sample(pick_sample(1'b0), 1'b0, DEC_IDLE);
        wait_idle();
        write_reg(REG_WINDOW_LENGTH, 16'd50);
        repeat (samples_to_window_end())
            send_sample(pick_sample(1'b0), 1'b0, DEC_IDLE);
        // longest window, short run then closed at a shorter length
        wait_idle();
        write_reg(REG_WINDOW_LENGTH, 16'hFFFF);
        repeat (60)
            send_sample(pick_sample(1'b1), 1'b0, DEC_IDLE);
        wait_idle();
        write_reg(REG_WINDOW_LENGTH, 16'd70);
        repeat (samples_to_window_end())
            send_sample(pick_sample(1'b1), 1'b0, DEC_IDLE);

        // Random settings under each idling pattern
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (int set = 0; set < 8; set++)
            begin
                wait_idle();
                if ($urandom_range(4) != 0)
                    write_reg(REG_WINDOW_LENGTH, pick_window());
                if ($urandom_range(3) == 0)
                    write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
                write_reg(REG_CODE_WORD, {1'($urandom_range(1)), pick_code()});
                positive = 1'($urandom_range(1));
                repeat ($urandom_range(90, 20))
                    send_sample(pick_sample(positive), 1'b0, DEC_IDLE);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_decisions.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
